FILE: rtl/rce_pkg.sv
// Shared widths, codes and controller/datapath interface types for the rotor cipher engine.
package rce_pkg;

  localparam int SYM_W      = 9;
  localparam int IDX_W      = 8;
  localparam int SLOT_W     = 3;
  localparam int TYPE_W     = 3;
  localparam int ROT_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam int DEF_MAX_ALPHA  = 256;
  localparam int DEF_MAX_ROTORS = 8;

  localparam int RESET_ALPHA  = 26;
  localparam int RESET_ROTORS = 3;

  localparam int MOD_BPC   = 3;
  localparam int MOD_CYC   = (SYM_W + MOD_BPC - 1) / MOD_BPC;
  localparam int MOD_PAD_W = MOD_CYC * MOD_BPC;
  localparam int MOD_CNT_W = $clog2(MOD_CYC + 1);

  localparam logic [TYPE_W-1:0] REQ_WIRING  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_NOTCH   = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_START   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_ENCRYPT = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REFL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTORS_IN_USE = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CFG,
    OP_WRITE,
    OP_CLEAR,
    OP_MOD_VALUE,
    OP_MOD_OFFS,
    OP_NORM_WB,
    OP_SETPOS,
    OP_ENC_INIT,
    OP_RD_A,
    OP_RD_T,
    OP_NOTCH,
    OP_FWD_DONE,
    OP_REFL_RD,
    OP_MOD_REFL,
    OP_REFL_DONE,
    OP_INV_RD,
    OP_MOD_INV,
    OP_INV_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic j_last;
    logic j_first;
    logic j_end;
  } stat_t;

endpackage

FILE: rtl/rotor_cipher_engine.sv
// Rotor cipher engine top level: generalized rotor machine over symbols 1..n.
// Input beats are taken when start is high and busy is low; fields are
// in_req_type, in_slot, in_entry_index and in_value. Load, notch and
// reflector beats go through a write state; a start position beat waits for
// the remainder unit. An encrypt beat gives one out_symbol beat, marked by
// out_valid for one cycle; busy stays high meanwhile. Each encrypt beat runs
// through the single remainder unit (3 dividend bits per cycle) and the
// registered table reads, walked once forward and once backward per rotor
// in use. Other beats give no result.
// Configuration beats on cfg_valid/cfg_ready (cfg_index, cfg_data) are taken
// while busy is low and start is low; a write of the alphabet size then
// reduces every rotor offset modulo the new size, with busy held high.
// Reset (rst_n low, synchronous) restores n=26 and three rotors, zeroes the
// offsets and runs a clearing pass over the notch table of
// MAX_ROTORS*2^ceil(log2(MAX_ALPHA)) entries (2048 by default) with busy
// high. Wiring, inverse and reflector tables hold no value until loaded.
// The receiver cannot stall: each result is shown for exactly one cycle.
module rotor_cipher_engine #(
  parameter int MAX_ALPHA  = rce_pkg::DEF_MAX_ALPHA,
  parameter int MAX_ROTORS = rce_pkg::DEF_MAX_ROTORS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rce_pkg::TYPE_W-1:0]     in_req_type,
  input  logic [rce_pkg::SLOT_W-1:0]     in_slot,
  input  logic [rce_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [rce_pkg::SYM_W-1:0]      in_value,
  output logic                           out_valid,
  output logic [rce_pkg::SYM_W-1:0]      out_symbol,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data
);

  rce_pkg::cmd_t  cmd;
  rce_pkg::stat_t stat;

  rce_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .cfg_ready   (cfg_ready)
  );

  rce_dp #(
    .MAX_ALPHA  (MAX_ALPHA),
    .MAX_ROTORS (MAX_ROTORS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_slot        (in_slot),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_symbol     (out_symbol)
  );

endmodule

FILE: rtl/rce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rce_ram #(
  parameter int W     = 1,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rce_mod.sv
// Multi-cycle remainder unit: x mod n, a few dividend bits per cycle.
module rce_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rce_pkg::SYM_W-1:0] x,
  input  logic [rce_pkg::SYM_W-1:0] n,
  output logic                      done,
  output logic [rce_pkg::SYM_W-1:0] rem
);

  localparam int SW  = rce_pkg::SYM_W;
  localparam int BPC = rce_pkg::MOD_BPC;
  localparam int PAD = rce_pkg::MOD_PAD_W;
  localparam int CW  = rce_pkg::MOD_CNT_W;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [PAD-1:0] xs_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] rem_nxt;

  always_comb begin
    logic [SW:0] tmp;
    rem_nxt = rem_r;
    for (int i = 0; i < BPC; i++) begin
      tmp = {rem_nxt, xs_r[PAD-1-i]};
      if (tmp >= {1'b0, n}) begin
        tmp = tmp - {1'b0, n};
      end
      rem_nxt = tmp[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(rce_pkg::MOD_CYC);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs_r  <= PAD'(x);
      rem_r <= '0;
    end else if (busy_r) begin
      xs_r  <= xs_r << BPC;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/rce_ctrl.sv
// Controller state machine: sequences item handling, clearing pass and offset normalization.
module rce_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rce_pkg::TYPE_W-1:0]    in_req_type,
  input  logic                          cfg_valid,
  input  logic [rce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  rce_pkg::stat_t                stat,
  output rce_pkg::cmd_t                 cmd,
  output logic                          busy,
  output logic                          cfg_ready
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_POS_MOD,
    S_POS_WAIT,
    S_NORM_MOD,
    S_NORM_WAIT,
    S_ENC_MOD,
    S_ENC_WAIT,
    S_RD_A,
    S_RD_T,
    S_NOTCH,
    S_FWD_WAIT,
    S_REFL_RD,
    S_REFL_MOD,
    S_REFL_WAIT,
    S_INV_RD,
    S_INV_MOD,
    S_INV_WAIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r & ~start;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rce_pkg::OP_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.op = rce_pkg::OP_CLEAR;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = rce_pkg::OP_LOAD;
          if (in_req_type == rce_pkg::REQ_WIRING || in_req_type == rce_pkg::REQ_NOTCH ||
              in_req_type == rce_pkg::REQ_REFL) begin
            state_nxt = S_WRITE;
          end else if (in_req_type == rce_pkg::REQ_START) begin
            state_nxt = S_POS_MOD;
          end else if (in_req_type == rce_pkg::REQ_ENCRYPT) begin
            state_nxt = S_ENC_MOD;
          end
        end else if (cfg_valid) begin
          cmd.op = rce_pkg::OP_CFG;
          if (cfg_index == rce_pkg::REG_ALPHABET_SIZE) begin
            state_nxt = S_NORM_MOD;
          end
        end
      end
      S_WRITE: begin
        cmd.op    = rce_pkg::OP_WRITE;
        state_nxt = S_IDLE;
      end
      S_POS_MOD: begin
        cmd.op    = rce_pkg::OP_MOD_VALUE;
        state_nxt = S_POS_WAIT;
      end
      S_POS_WAIT: begin
        if (stat.mod_done) begin
          cmd.op    = rce_pkg::OP_SETPOS;
          state_nxt = S_IDLE;
        end
      end
      S_NORM_MOD: begin
        cmd.op    = rce_pkg::OP_MOD_OFFS;
        state_nxt = S_NORM_WAIT;
      end
      S_NORM_WAIT: begin
        if (stat.mod_done) begin
          cmd.op    = rce_pkg::OP_NORM_WB;
          state_nxt = stat.j_end ? S_IDLE : S_NORM_MOD;
        end
      end
      S_ENC_MOD: begin
        cmd.op    = rce_pkg::OP_MOD_VALUE;
        state_nxt = S_ENC_WAIT;
      end
      S_ENC_WAIT: begin
        if (stat.mod_done) begin
          cmd.op    = rce_pkg::OP_ENC_INIT;
          state_nxt = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd.op    = rce_pkg::OP_RD_A;
        state_nxt = S_RD_T;
      end
      S_RD_T: begin
        cmd.op    = rce_pkg::OP_RD_T;
        state_nxt = S_NOTCH;
      end
      S_NOTCH: begin
        cmd.op    = rce_pkg::OP_NOTCH;
        state_nxt = S_FWD_WAIT;
      end
      S_FWD_WAIT: begin
        if (stat.mod_done) begin
          cmd.op    = rce_pkg::OP_FWD_DONE;
          state_nxt = stat.j_last ? S_REFL_RD : S_RD_A;
        end
      end
      S_REFL_RD: begin
        cmd.op    = rce_pkg::OP_REFL_RD;
        state_nxt = S_REFL_MOD;
      end
      S_REFL_MOD: begin
        cmd.op    = rce_pkg::OP_MOD_REFL;
        state_nxt = S_REFL_WAIT;
      end
      S_REFL_WAIT: begin
        if (stat.mod_done) begin
          cmd.op    = rce_pkg::OP_REFL_DONE;
          state_nxt = S_INV_RD;
        end
      end
      S_INV_RD: begin
        cmd.op    = rce_pkg::OP_INV_RD;
        state_nxt = S_INV_MOD;
      end
      S_INV_MOD: begin
        cmd.op    = rce_pkg::OP_MOD_INV;
        state_nxt = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (stat.mod_done) begin
          cmd.op    = rce_pkg::OP_INV_DONE;
          state_nxt = stat.j_first ? S_IDLE : S_INV_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

FILE: rtl/rce_dp.sv
// Datapath: configuration, offsets, rotor tables, remainder unit and result register.
module rce_dp #(
  parameter int MAX_ALPHA  = rce_pkg::DEF_MAX_ALPHA,
  parameter int MAX_ROTORS = rce_pkg::DEF_MAX_ROTORS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rce_pkg::cmd_t                  cmd,
  output rce_pkg::stat_t                 stat,
  input  logic [rce_pkg::TYPE_W-1:0]     in_req_type,
  input  logic [rce_pkg::SLOT_W-1:0]     in_slot,
  input  logic [rce_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [rce_pkg::SYM_W-1:0]      in_value,
  input  logic [rce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic [rce_pkg::SYM_W-1:0]      out_symbol
);

  localparam int SW        = rce_pkg::SYM_W;
  localparam int SW1       = SW + 1;
  localparam int IW        = rce_pkg::IDX_W;
  localparam int PW        = $clog2(MAX_ALPHA);
  localparam int RW        = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
  localparam int TBL_DEPTH = MAX_ROTORS << PW;
  localparam int TAW       = $clog2(TBL_DEPTH);
  localparam int N_RST     = (rce_pkg::RESET_ALPHA > MAX_ALPHA) ? MAX_ALPHA
                                                                : rce_pkg::RESET_ALPHA;
  localparam int R_RST     = (rce_pkg::RESET_ROTORS > MAX_ROTORS) ? MAX_ROTORS
                                                                  : rce_pkg::RESET_ROTORS;

  logic [rce_pkg::TYPE_W-1:0] it_type_r;
  logic [rce_pkg::SLOT_W-1:0] it_slot_r;
  logic [IW-1:0]              it_idx_r;
  logic [SW-1:0]              it_val_r;

  logic [SW-1:0]  n_r;
  logic [RW-1:0]  rl_r;
  logic [RW-1:0]  j_r;
  logic [SW-1:0]  pos_r;
  logic [SW-1:0]  y_r;
  logic           step_r;
  logic           elig_r;
  logic [SW-1:0]  offs_r [MAX_ROTORS];
  logic [TAW-1:0] clr_r;
  logic           out_valid_r;
  logic [SW-1:0]  out_symbol_r;

  logic [SW-1:0]  n_cfg;
  logic [RW-1:0]  rl_cfg;
  logic [ROT_MSB:0] rv;
  localparam int ROT_MSB = rce_pkg::ROT_W - 1;

  logic [SW-1:0]  t;
  logic [SW1-1:0] t_inc;
  logic [SW-1:0]  t_step;
  logic [SW-1:0]  t_eff;
  logic [SW1-1:0] a_sum;
  logic [SW-1:0]  a_pos;
  logic [SW-1:0]  sp_pos;
  logic [SW1-1:0] f_sum;
  logic [SW-1:0]  f_pos;
  logic [SW1-1:0] b_sum;
  logic [SW-1:0]  b_m;
  logic [SW-1:0]  b_addr;
  logic [SW1-1:0] d_sum;
  logic [SW-1:0]  d_pos;
  logic [SW-1:0]  y_new;
  logic           w_ok;
  logic           slot_ok;
  logic           idx_ok;
  logic           val_ok;
  logic [RW-1:0]  it_slot_rw;

  logic           mod_start;
  logic [SW-1:0]  mod_x;
  logic           mod_done;
  logic [SW-1:0]  mrem;

  logic           wir_we;
  logic [TAW-1:0] wir_waddr;
  logic           wir_re;
  logic [TAW-1:0] wir_raddr;
  logic [SW-1:0]  wir_rdata;
  logic           inv_we;
  logic [TAW-1:0] inv_waddr;
  logic           inv_re;
  logic [TAW-1:0] inv_raddr;
  logic [IW-1:0]  inv_rdata;
  logic           nch_we;
  logic [TAW-1:0] nch_waddr;
  logic           nch_wdata;
  logic           nch_re;
  logic [TAW-1:0] nch_raddr;
  logic           nch_rdata;
  logic           rfl_we;
  logic [PW-1:0]  rfl_waddr;
  logic           rfl_re;
  logic [PW-1:0]  rfl_raddr;
  logic [SW-1:0]  rfl_rdata;

  // Clamp configuration values to their usable ranges.
  always_comb begin
    rv = cfg_data[ROT_MSB:0];
    if (cfg_data < SW'(2)) begin
      n_cfg = SW'(2);
    end else if (int'(cfg_data) > MAX_ALPHA) begin
      n_cfg = SW'(MAX_ALPHA);
    end else begin
      n_cfg = cfg_data;
    end
    if (rv == '0) begin
      rl_cfg = '0;
    end else if (int'(rv) > MAX_ROTORS) begin
      rl_cfg = RW'(MAX_ROTORS - 1);
    end else begin
      rl_cfg = RW'(rv - 1'b1);
    end
  end

  always_comb begin
    t      = offs_r[j_r];
    t_inc  = {1'b0, t} + SW1'(1);
    t_step = (t_inc == {1'b0, n_r}) ? '0 : t_inc[SW-1:0];
    t_eff  = step_r ? t_step : t;

    a_sum = {1'b0, pos_r} + {1'b0, t_eff};
    a_pos = (a_sum >= {1'b0, n_r}) ? SW'(a_sum - {1'b0, n_r}) : a_sum[SW-1:0];

    sp_pos = (mrem == '0) ? (n_r - 1'b1) : (mrem - 1'b1);

    f_sum = {1'b0, mrem} + {1'b0, n_r} - SW1'(1) - {1'b0, t};
    f_pos = (f_sum >= {1'b0, n_r}) ? SW'(f_sum - {1'b0, n_r}) : f_sum[SW-1:0];

    b_sum  = {1'b0, y_r} + {1'b0, t};
    b_m    = (b_sum >= {1'b0, n_r}) ? SW'(b_sum - {1'b0, n_r}) : b_sum[SW-1:0];
    b_addr = (b_m == '0) ? (n_r - 1'b1) : (b_m - 1'b1);

    d_sum = {1'b0, mrem} + {1'b0, n_r} - {1'b0, t};
    d_pos = (d_sum >= {1'b0, n_r}) ? SW'(d_sum - {1'b0, n_r}) : d_sum[SW-1:0];
    y_new = d_pos + 1'b1;

    w_ok       = (wir_rdata != '0) && (int'(wir_rdata) <= MAX_ALPHA);
    slot_ok    = int'(it_slot_r) < MAX_ROTORS;
    idx_ok     = int'(it_idx_r) < MAX_ALPHA;
    val_ok     = (it_val_r != '0) && (int'(it_val_r) <= MAX_ALPHA);
    it_slot_rw = RW'(it_slot_r);
  end

  // Table ports and remainder unit operand.
  always_comb begin
    wir_we    = 1'b0;
    wir_waddr = TAW'({it_slot_rw, PW'(it_idx_r)});
    wir_re    = 1'b0;
    wir_raddr = TAW'({j_r, PW'(a_pos)});
    inv_we    = 1'b0;
    inv_waddr = TAW'({it_slot_rw, PW'(it_val_r - 1'b1)});
    inv_re    = 1'b0;
    inv_raddr = TAW'({j_r, PW'(b_addr)});
    nch_we    = 1'b0;
    nch_waddr = TAW'({it_slot_rw, PW'(it_idx_r)});
    nch_wdata = it_val_r[0];
    nch_re    = 1'b0;
    nch_raddr = TAW'({j_r, PW'(wir_rdata - 1'b1)});
    rfl_we    = 1'b0;
    rfl_waddr = PW'(it_idx_r);
    rfl_re    = 1'b0;
    rfl_raddr = PW'(pos_r);
    mod_start = 1'b0;
    mod_x     = it_val_r;
    case (cmd.op)
      rce_pkg::OP_CLEAR: begin
        nch_we    = 1'b1;
        nch_waddr = clr_r;
        nch_wdata = 1'b0;
      end
      rce_pkg::OP_WRITE: begin
        if (it_type_r == rce_pkg::REQ_WIRING) begin
          wir_we = slot_ok && idx_ok;
          inv_we = slot_ok && idx_ok && val_ok;
        end else if (it_type_r == rce_pkg::REQ_NOTCH) begin
          nch_we = slot_ok && idx_ok;
        end else if (it_type_r == rce_pkg::REQ_REFL) begin
          rfl_we = idx_ok;
        end
      end
      rce_pkg::OP_MOD_VALUE: begin
        mod_start = 1'b1;
      end
      rce_pkg::OP_MOD_OFFS: begin
        mod_start = 1'b1;
        mod_x     = t;
      end
      rce_pkg::OP_RD_A: begin
        wir_re = 1'b1;
      end
      rce_pkg::OP_RD_T: begin
        wir_re    = 1'b1;
        wir_raddr = TAW'({j_r, PW'(t)});
        mod_start = 1'b1;
        mod_x     = wir_rdata;
      end
      rce_pkg::OP_NOTCH: begin
        nch_re = 1'b1;
      end
      rce_pkg::OP_REFL_RD: begin
        rfl_re = 1'b1;
      end
      rce_pkg::OP_MOD_REFL: begin
        mod_start = 1'b1;
        mod_x     = rfl_rdata;
      end
      rce_pkg::OP_INV_RD: begin
        inv_re = 1'b1;
      end
      rce_pkg::OP_MOD_INV: begin
        mod_start = 1'b1;
        mod_x     = SW'(inv_rdata);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= SW'(N_RST);
      rl_r        <= RW'(R_RST - 1);
      j_r         <= '0;
      step_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ROTORS; i++) begin
        offs_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      case (cmd.op)
        rce_pkg::OP_CFG: begin
          if (cfg_index == rce_pkg::REG_ALPHABET_SIZE) begin
            n_r <= n_cfg;
            j_r <= '0;
          end else if (cfg_index == rce_pkg::REG_ROTORS_IN_USE) begin
            rl_r <= rl_cfg;
          end
        end
        rce_pkg::OP_CLEAR: begin
          clr_r <= clr_r + 1'b1;
        end
        rce_pkg::OP_SETPOS: begin
          if (slot_ok) begin
            offs_r[it_slot_rw] <= sp_pos;
          end
        end
        rce_pkg::OP_NORM_WB: begin
          offs_r[j_r] <= mrem;
          if (j_r != RW'(MAX_ROTORS - 1)) begin
            j_r <= j_r + 1'b1;
          end
        end
        rce_pkg::OP_ENC_INIT: begin
          j_r    <= '0;
          step_r <= 1'b1;
        end
        rce_pkg::OP_RD_A: begin
          offs_r[j_r] <= t_eff;
          step_r      <= 1'b0;
        end
        rce_pkg::OP_FWD_DONE: begin
          step_r <= elig_r & nch_rdata;
          if (j_r != rl_r) begin
            j_r <= j_r + 1'b1;
          end
        end
        rce_pkg::OP_INV_DONE: begin
          if (j_r == '0) begin
            out_valid_r <= 1'b1;
          end else begin
            j_r <= j_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rce_pkg::OP_LOAD: begin
        it_type_r <= in_req_type;
        it_slot_r <= in_slot;
        it_idx_r  <= in_entry_index;
        it_val_r  <= in_value;
      end
      rce_pkg::OP_ENC_INIT: begin
        pos_r <= sp_pos;
      end
      rce_pkg::OP_NOTCH: begin
        elig_r <= (j_r != rl_r) && w_ok;
      end
      rce_pkg::OP_FWD_DONE: begin
        pos_r <= f_pos;
      end
      rce_pkg::OP_REFL_DONE: begin
        y_r <= mrem;
      end
      rce_pkg::OP_INV_DONE: begin
        y_r          <= y_new;
        out_symbol_r <= y_new;
      end
      default: begin
      end
    endcase
  end

  assign stat.clr_done = (clr_r == TAW'(TBL_DEPTH - 1));
  assign stat.mod_done = mod_done;
  assign stat.j_last   = (j_r == rl_r);
  assign stat.j_first  = (j_r == '0);
  assign stat.j_end    = (j_r == RW'(MAX_ROTORS - 1));

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;

  rce_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .x     (mod_x),
    .n     (n_r),
    .done  (mod_done),
    .rem   (mrem)
  );

  rce_ram #(.W(SW), .DEPTH(TBL_DEPTH)) u_wiring (
    .clk   (clk),
    .we    (wir_we),
    .waddr (wir_waddr),
    .wdata (it_val_r),
    .re    (wir_re),
    .raddr (wir_raddr),
    .rdata (wir_rdata)
  );

  rce_ram #(.W(IW), .DEPTH(TBL_DEPTH)) u_inverse (
    .clk   (clk),
    .we    (inv_we),
    .waddr (inv_waddr),
    .wdata (it_idx_r),
    .re    (inv_re),
    .raddr (inv_raddr),
    .rdata (inv_rdata)
  );

  rce_ram #(.W(1), .DEPTH(TBL_DEPTH)) u_notch (
    .clk   (clk),
    .we    (nch_we),
    .waddr (nch_waddr),
    .wdata (nch_wdata),
    .re    (nch_re),
    .raddr (nch_raddr),
    .rdata (nch_rdata)
  );

  rce_ram #(.W(SW), .DEPTH(MAX_ALPHA)) u_reflector (
    .clk   (clk),
    .we    (rfl_we),
    .waddr (rfl_waddr),
    .wdata (it_val_r),
    .re    (rfl_re),
    .raddr (rfl_raddr),
    .rdata (rfl_rdata)
  );

endmodule
